/* design/wsdfr_pkg.sv */
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; compiled first.
package wsdfr_pkg;

    // Widths of the result fields
    localparam int unsigned LEN_W  = 64;
    localparam int unsigned KEY_W  = 32;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned OPC_W  = 4;

    // Result kinds
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // One result beat as it travels from the parser through the queue
    typedef struct packed {
        logic              kind;
        logic              final_fragment;
        logic [OPC_W-1:0]  opcode;
        logic              is_masked;
        logic [LEN_W-1:0]  frame_length;
        logic [KEY_W-1:0]  mask_word;
        logic [BYTE_W-1:0] payload_byte;
        logic              last;
    } wsdfr_res_t;

endpackage

/* design/wsdfr_parser.sv */
// Front part of the deframer: walks the frame header byte by byte and
// unmasks payload bytes. Depends on wsdfr_pkg.
module wsdfr_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [7:0]             rx_byte,
    output logic                   res_valid,
    output wsdfr_pkg::wsdfr_res_t  res
);
    import wsdfr_pkg::*;

    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXT16   = 3'd2;
    localparam logic [2:0] PH_EXT64   = 3'd3;
    localparam logic [2:0] PH_KEY     = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [2:0] EXT16_LAST  = 3'd1;
    localparam logic [2:0] EXT64_LAST  = 3'd7;
    localparam logic [2:0] KEY_LAST    = 3'd3;

    logic [2:0]        phase_reg,   phase_next;
    logic [2:0]        cnt_reg,     cnt_next;
    logic              fin_reg,     fin_next;
    logic [OPC_W-1:0]  opcode_reg,  opcode_next;
    logic              mask_reg,    mask_next;
    logic [LEN_W-1:0]  len_reg,     len_next;
    logic [KEY_W-1:0]  key_reg,     key_next;
    logic [LEN_W-1:0]  remain_reg,  remain_next;
    logic [1:0]        kidx_reg,    kidx_next;

    logic              emit_hdr;
    logic              emit_pay;
    logic              pay_last;
    logic [7:0]        key_byte;

    // Select the key byte for the current payload position, first byte on top
    always_comb
    begin
        case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Advance the parse state on each accepted beat
    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        remain_next = remain_reg;
        kidx_next   = kidx_reg;
        emit_hdr    = 1'b0;
        emit_pay    = 1'b0;
        pay_last    = 1'b0;

        if (in_valid)
        begin
            case (phase_reg)
                PH_HDR1:
                begin
                    mask_next = rx_byte[7];
                    cnt_next  = 3'd0;
                    len_next  = '0;
                    if (rx_byte[6:0] == LEN_CODE_16)
                    begin
                        phase_next = PH_EXT16;
                    end
                    else if (rx_byte[6:0] == LEN_CODE_64)
                    begin
                        phase_next = PH_EXT64;
                    end
                    else
                    begin
                        len_next = {{(LEN_W-7){1'b0}}, rx_byte[6:0]};
                        if (rx_byte[7])
                            phase_next = PH_KEY;
                        else
                            emit_hdr = 1'b1;
                    end
                end
                PH_EXT16, PH_EXT64:
                begin
                    len_next = {len_reg[LEN_W-9:0], rx_byte};
                    if (cnt_reg >= ((phase_reg == PH_EXT16) ? EXT16_LAST : EXT64_LAST))
                    begin
                        cnt_next = 3'd0;
                        if (mask_reg)
                            phase_next = PH_KEY;
                        else
                            emit_hdr = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                PH_KEY:
                begin
                    key_next = {key_reg[KEY_W-9:0], rx_byte};
                    if (cnt_reg >= KEY_LAST)
                        emit_hdr = 1'b1;
                    else
                        cnt_next = cnt_reg + 3'd1;
                end
                PH_PAYLOAD:
                begin
                    emit_pay    = 1'b1;
                    kidx_next   = kidx_reg + 2'd1;
                    remain_next = remain_reg - {{(LEN_W-1){1'b0}}, 1'b1};
                    pay_last    = (remain_next == '0);
                    if (pay_last)
                        phase_next = PH_HDR0;
                end
                default:
                begin
                    fin_next    = rx_byte[7];
                    opcode_next = rx_byte[OPC_W-1:0];
                    mask_next   = 1'b0;
                    len_next    = '0;
                    key_next    = '0;
                    remain_next = '0;
                    kidx_next   = 2'd0;
                    cnt_next    = 3'd0;
                    phase_next  = PH_HDR1;
                end
            endcase

            // Header complete: arm the payload count or close an empty frame
            if (emit_hdr)
            begin
                remain_next = len_next;
                kidx_next   = 2'd0;
                cnt_next    = 3'd0;
                phase_next  = (len_next == '0) ? PH_HDR0 : PH_PAYLOAD;
            end
        end
    end

    // Build the result beat from the updated frame fields
    always_comb
    begin
        res_valid          = emit_hdr | emit_pay;
        res.kind           = emit_pay ? KIND_PAYLOAD : KIND_HEADER;
        res.final_fragment = fin_next;
        res.opcode         = opcode_next;
        res.is_masked      = mask_next;
        res.frame_length   = len_next;
        res.mask_word      = key_next;
        res.payload_byte   = emit_pay ? (rx_byte ^ key_byte) : 8'd0;
        res.last           = emit_pay ? pay_last : (len_next == '0);
    end

    // Hold the parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            cnt_reg    <= 3'd0;
            fin_reg    <= 1'b0;
            opcode_reg <= '0;
            mask_reg   <= 1'b0;
            len_reg    <= '0;
            key_reg    <= '0;
            remain_reg <= '0;
            kidx_reg   <= 2'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            mask_reg   <= mask_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            remain_reg <= remain_next;
            kidx_reg   <= kidx_next;
        end
    end

endmodule

/* design/wsdfr_queue.sv */
// Back part of the deframer: a short result queue that presents the oldest
// beat on its outputs. Depends on wsdfr_pkg.
module wsdfr_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  wsdfr_pkg::wsdfr_res_t  wr_data,
    input  logic                   rd_en,
    output wsdfr_pkg::wsdfr_res_t  rd_data,
    output logic                   full,
    output logic                   empty
);
    import wsdfr_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    wsdfr_res_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
        if (wr_en && !rd_en)
            count_next = count_reg + CNT_ONE;
        else if (rd_en && !wr_en)
            count_next = count_reg - CNT_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

/* design/websocket_frame_deframer.sv */
// Top level of the WebSocket frame deframer: header parser in front, result
// queue behind. Depends on wsdfr_pkg, wsdfr_parser and wsdfr_queue.
//
//   channel   handshake          payload
//   input     push / full        rx_byte
//   result    empty / pop        kind, final_fragment, opcode, is_masked,
//                                frame_length, mask_word, payload_byte, last
//
// One byte is taken per cycle while full is low; the parser updates its phase
// and unmasks in the same cycle and writes at most one result into the queue.
// A result shows on the outputs once every older result has been popped.
// full rises only when QUEUE_DEPTH results wait; the parser then stalls.
// rst_n clears the parser to await the first header byte and empties the queue.
module websocket_frame_deframer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [7:0]   rx_byte,
    output logic         empty,
    input  logic         pop,
    output logic         kind,
    output logic         final_fragment,
    output logic [3:0]   opcode,
    output logic         is_masked,
    output logic [63:0]  frame_length,
    output logic [31:0]  mask_word,
    output logic [7:0]   payload_byte,
    output logic         last
);
    import wsdfr_pkg::*;

    logic        in_beat;
    logic        out_beat;
    logic        res_valid;
    wsdfr_res_t  res;
    wsdfr_res_t  head;

    // Accept a beat on each side
    assign in_beat  = push & ~full;
    assign out_beat = pop & ~empty;

    wsdfr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_beat),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    wsdfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .rd_en   (out_beat),
        .rd_data (head),
        .full    (full),
        .empty   (empty)
    );

    // Present the oldest result
    assign kind           = head.kind;
    assign final_fragment = head.final_fragment;
    assign opcode         = head.opcode;
    assign is_masked      = head.is_masked;
    assign frame_length   = head.frame_length;
    assign mask_word      = head.mask_word;
    assign payload_byte   = head.payload_byte;
    assign last           = head.last;

endmodule
